// ===== hdl/sodf_pkg.sv =====
package sodf_pkg;

    localparam int SIG_W       = 32;
    localparam int COEF_W      = 48;
    localparam int INERT_W     = COEF_W - 1;
    localparam int STEP_W      = 32;
    localparam int VEL_W       = SIG_W + 16;
    localparam int FRAC_SH     = 32;
    localparam int SUM_W       = VEL_W + 3;
    localparam int T1_W        = 64;
    localparam int AMT_W       = 84;
    localparam int INC_W       = VEL_W + 2;

    localparam int MUL_A_W     = AMT_W;
    localparam int MUL_B_W     = COEF_W;
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W     = 112;
    localparam int DIV_D_W     = INERT_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(89478);

    typedef logic signed [SIG_W-1:0]  signal_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [INERT_W-1:0]       inertia_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic signed [VEL_W-1:0]  velocity_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_MUL,
        ST_POS_WAIT,
        ST_T1_MUL,
        ST_T1_WAIT,
        ST_T3_MUL,
        ST_T3_WAIT,
        ST_T3_DIV,
        ST_T3_DWAIT,
        ST_SUM,
        ST_INC_MUL,
        ST_INC_WAIT,
        ST_INC_DIV,
        ST_INC_DWAIT,
        ST_VEL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_POS,
        MUL_T1,
        MUL_T3,
        MUL_INC
    } mul_sel_t;

    typedef enum logic {
        DIV_T3,
        DIV_INC
    } div_sel_t;

    typedef struct packed {
        logic     take;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_pos;
        logic     cap_t1;
        logic     cap_t3_zero;
        logic     cap_t3;
        logic     cap_amount;
        logic     cap_vel;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic mul_done;
        logic div_done;
        logic step_zero;
        logic inertia_zero;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sodf_if.sv =====
interface sodf_cfg_if;
    logic            valid;
    logic            ready;
    sodf_pkg::step_t time_step;

    modport source (output valid, output time_step, input ready);
    modport sink (input valid, input time_step, output ready);
endinterface

interface sodf_sample_if;
    logic                valid;
    logic                ready;
    sodf_pkg::signal_t   target;
    sodf_pkg::coef_t     damping_coef;
    sodf_pkg::inertia_t  inertia_coef;
    sodf_pkg::coef_t     anticipation_coef;

    modport source (
        output valid, output target, output damping_coef, output inertia_coef,
        output anticipation_coef, input ready
    );
    modport sink (
        input valid, input target, input damping_coef, input inertia_coef,
        input anticipation_coef, output ready
    );
endinterface

interface sodf_result_if;
    logic              valid;
    logic              ready;
    sodf_pkg::signal_t position;
    logic              saturated;
    logic              coef_error;

    modport source (
        output valid, output position, output saturated, output coef_error, input ready
    );
    modport sink (
        input valid, input position, input saturated, input coef_error, output ready
    );
endinterface

// ===== hdl/sodf_mul.sv =====
module sodf_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sodf_pkg::MUL_A_W-1:0]  a,
    input  logic [sodf_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [sodf_pkg::PROD_W-1:0]   prod
);

    localparam int DIG_W = sodf_pkg::MUL_DIGIT_W;
    localparam int CNT_W = $clog2(sodf_pkg::MUL_STEPS);

    logic [sodf_pkg::MUL_A_W-1:0]       a_reg;
    logic [sodf_pkg::MUL_B_W-1:0]       b_reg;
    logic [sodf_pkg::PROD_W-1:0]        prod_reg;
    logic [sodf_pkg::PROD_W-1:0]        prod_next;
    logic [sodf_pkg::MUL_A_W+DIG_W-1:0] pp;
    logic [CNT_W-1:0]                   cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    // one digit of b per cycle, msb first
    assign pp        = a_reg * b_reg[sodf_pkg::MUL_B_W-1 -: DIG_W];
    assign prod_next = (prod_reg << DIG_W) + sodf_pkg::PROD_W'(pp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(sodf_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            b_reg    <= b_reg << DIG_W;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hdl/sodf_div.sv =====
module sodf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sodf_pkg::DIV_N_W-1:0]  num,
    input  logic [sodf_pkg::DIV_D_W-1:0]  den,
    output logic                          done,
    output logic [sodf_pkg::DIV_N_W-1:0]  quo
);

    localparam int N_W   = sodf_pkg::DIV_N_W;
    localparam int D_W   = sodf_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   nq_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W:0]     shifted;
    logic [D_W:0]     trial;
    logic             ge;
    logic [D_W-1:0]   rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // restoring division, one quotient bit per cycle
    assign shifted  = {rem_reg, nq_reg[N_W-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign ge       = shifted >= {1'b0, den_reg};
    assign rem_next = ge ? trial[D_W-1:0] : shifted[D_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

// ===== hdl/sodf_datapath.sv =====
module sodf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    sodf_cfg_if.sink              cfg,
    sodf_sample_if.sink           sample,
    sodf_result_if.source         result,
    input  sodf_pkg::cmd_t        cmd,
    output sodf_pkg::status_t     status
);

    localparam int SIG_W   = sodf_pkg::SIG_W;
    localparam int COEF_W  = sodf_pkg::COEF_W;
    localparam int VEL_W   = sodf_pkg::VEL_W;
    localparam int SUM_W   = sodf_pkg::SUM_W;
    localparam int AMT_W   = sodf_pkg::AMT_W;
    localparam int INC_W   = sodf_pkg::INC_W;
    localparam int T1_W    = sodf_pkg::T1_W;
    localparam int FRAC_SH = sodf_pkg::FRAC_SH;
    localparam int PROD_W  = sodf_pkg::PROD_W;
    localparam int N_W     = sodf_pkg::DIV_N_W;

    sodf_pkg::step_t     time_step_reg;
    sodf_pkg::signal_t   tgt_reg;
    sodf_pkg::coef_t     k1_reg;
    sodf_pkg::inertia_t  k2_reg;
    sodf_pkg::coef_t     k3_reg;
    sodf_pkg::signal_t   last_reg;
    sodf_pkg::signal_t   pos_reg;
    sodf_pkg::velocity_t vel_reg;

    sodf_pkg::signal_t         p_reg;
    logic signed [T1_W-1:0]    t1_reg;
    logic signed [AMT_W-1:0]   t3_reg;
    logic signed [AMT_W-1:0]   amount_reg;
    sodf_pkg::velocity_t       vel_new_reg;
    logic                      sat_reg;
    logic                      mul_neg_reg;
    logic                      div_neg_reg;

    logic                      out_valid_reg;
    sodf_pkg::signal_t         position_reg;
    logic                      saturated_reg;
    logic                      coef_error_reg;

    logic                      take;
    logic [VEL_W-1:0]          vel_mag;
    logic [COEF_W-1:0]         k1_mag;
    logic [COEF_W-1:0]         k3_mag;
    logic signed [SIG_W:0]     diff;
    logic [SIG_W:0]            diff_mag;
    logic [AMT_W-1:0]          amount_mag;

    logic [sodf_pkg::MUL_A_W-1:0] mul_a;
    logic [sodf_pkg::MUL_B_W-1:0] mul_b;
    logic                         mul_neg;
    logic                         mul_done;
    logic [PROD_W-1:0]            mul_prod;
    logic signed [PROD_W-1:0]     prod_s;

    logic [sodf_pkg::DIV_D_W-1:0] div_den;
    logic                         div_done;
    logic [N_W-1:0]               div_quo;

    logic signed [SUM_W-1:0]   p_sum;
    logic                      p_fits;
    sodf_pkg::signal_t         p_clamped;
    logic [AMT_W-1:0]          q_amt;
    logic                      q_big;
    logic [INC_W-1:0]          inc_mag;
    logic signed [INC_W-1:0]   inc_s;
    logic signed [SUM_W-1:0]   v_sum;
    logic                      v_fits;
    sodf_pkg::velocity_t       v_clamped;

    assign take         = sample.valid && cmd.take;
    assign sample.ready = cmd.take;
    assign cfg.ready    = 1'b1;

    assign vel_mag    = vel_reg[VEL_W-1] ? VEL_W'(-vel_reg) : VEL_W'(vel_reg);
    assign k1_mag     = k1_reg[COEF_W-1] ? COEF_W'(-k1_reg) : COEF_W'(k1_reg);
    assign k3_mag     = k3_reg[COEF_W-1] ? COEF_W'(-k3_reg) : COEF_W'(k3_reg);
    assign diff       = (SIG_W+1)'(tgt_reg) - (SIG_W+1)'(last_reg);
    assign diff_mag   = diff[SIG_W] ? (SIG_W+1)'(-diff) : (SIG_W+1)'(diff);
    assign amount_mag = amount_reg[AMT_W-1] ? AMT_W'(-amount_reg) : AMT_W'(amount_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            sodf_pkg::MUL_POS:
            begin
                mul_a   = sodf_pkg::MUL_A_W'(vel_mag);
                mul_b   = sodf_pkg::MUL_B_W'(time_step_reg);
                mul_neg = vel_reg[VEL_W-1];
            end
            sodf_pkg::MUL_T1:
            begin
                mul_a   = sodf_pkg::MUL_A_W'(k1_mag);
                mul_b   = sodf_pkg::MUL_B_W'(vel_mag);
                mul_neg = k1_reg[COEF_W-1] ^ vel_reg[VEL_W-1];
            end
            sodf_pkg::MUL_T3:
            begin
                mul_a   = sodf_pkg::MUL_A_W'(k3_mag);
                mul_b   = sodf_pkg::MUL_B_W'(diff_mag);
                mul_neg = k3_reg[COEF_W-1] ^ diff[SIG_W];
            end
            sodf_pkg::MUL_INC:
            begin
                mul_a   = sodf_pkg::MUL_A_W'(amount_mag);
                mul_b   = sodf_pkg::MUL_B_W'(time_step_reg);
                mul_neg = amount_reg[AMT_W-1];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            sodf_pkg::DIV_T3:  div_den = sodf_pkg::DIV_D_W'(time_step_reg);
            sodf_pkg::DIV_INC: div_den = k2_reg;
            default:           div_den = k2_reg;
        endcase
    end

    sodf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    sodf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (mul_prod[N_W-1:0]),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign prod_s = mul_neg_reg ? -$signed(mul_prod) : $signed(mul_prod);

    // position advance, floor shift then clamp
    assign p_sum     = SUM_W'(pos_reg) + $signed(prod_s[FRAC_SH+SUM_W-1:FRAC_SH]);
    assign p_fits    = (p_sum[SUM_W-1:SIG_W-1] == '0) || (p_sum[SUM_W-1:SIG_W-1] == '1);
    assign p_clamped = p_fits ? p_sum[SIG_W-1:0] :
                       (p_sum[SUM_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}});

    // velocity increment, clamp to inc range then velocity range
    assign q_amt   = div_quo[AMT_W-1:0];
    assign q_big   = |div_quo[N_W-1:INC_W-1];
    assign inc_mag = q_big ? (div_neg_reg ? {1'b1, {(INC_W-1){1'b0}}} : {1'b0, {(INC_W-1){1'b1}}})
                           : {1'b0, div_quo[INC_W-2:0]};
    assign inc_s   = div_neg_reg ? -$signed(inc_mag) : $signed(inc_mag);
    assign v_sum   = SUM_W'(vel_reg) + SUM_W'(inc_s);
    assign v_fits  = (v_sum[SUM_W-1:VEL_W-1] == '0) || (v_sum[SUM_W-1:VEL_W-1] == '1);
    assign v_clamped = v_fits ? v_sum[VEL_W-1:0] :
                       (v_sum[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= sodf_pkg::STEP_RESET;
            last_reg      <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                time_step_reg <= cfg.time_step;
            end
            if (cmd.commit)
            begin
                pos_reg       <= p_reg;
                vel_reg       <= vel_new_reg;
                last_reg      <= tgt_reg;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tgt_reg     <= sample.target;
            k1_reg      <= sample.damping_coef;
            k2_reg      <= sample.inertia_coef;
            k3_reg      <= sample.anticipation_coef;
            vel_new_reg <= vel_reg;
            sat_reg     <= 1'b0;
        end
        if (cmd.mul_start)
        begin
            mul_neg_reg <= mul_neg;
        end
        if (cmd.div_start)
        begin
            div_neg_reg <= mul_neg_reg;
        end
        if (cmd.cap_pos)
        begin
            p_reg   <= p_clamped;
            sat_reg <= !p_fits;
        end
        if (cmd.cap_t1)
        begin
            t1_reg <= prod_s[FRAC_SH+T1_W-1:FRAC_SH];
        end
        if (cmd.cap_t3_zero)
        begin
            t3_reg <= '0;
        end
        else if (cmd.cap_t3)
        begin
            t3_reg <= div_neg_reg ? -$signed(q_amt) : $signed(q_amt);
        end
        if (cmd.cap_amount)
        begin
            amount_reg <= AMT_W'(tgt_reg) + t3_reg - AMT_W'(p_reg) - AMT_W'(t1_reg);
        end
        if (cmd.cap_vel)
        begin
            vel_new_reg <= v_clamped;
            sat_reg     <= sat_reg | !v_fits;
        end
        if (cmd.commit)
        begin
            position_reg   <= p_reg;
            saturated_reg  <= sat_reg;
            coef_error_reg <= (k2_reg == '0);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.position   = position_reg;
    assign result.saturated  = saturated_reg;
    assign result.coef_error = coef_error_reg;

    assign status.in_valid     = sample.valid;
    assign status.mul_done     = mul_done;
    assign status.div_done     = div_done;
    assign status.step_zero    = (time_step_reg == '0);
    assign status.inertia_zero = (k2_reg == '0);
    assign status.out_free     = !out_valid_reg || result.ready;

endmodule

// ===== hdl/sodf_ctrl.sv =====
module sodf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  sodf_pkg::status_t status,
    output sodf_pkg::cmd_t    cmd
);

    sodf_pkg::state_t state_reg;
    sodf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sodf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sodf_pkg::ST_IDLE:
                if (status.in_valid) state_next = sodf_pkg::ST_POS_MUL;
            sodf_pkg::ST_POS_MUL:
                state_next = sodf_pkg::ST_POS_WAIT;
            sodf_pkg::ST_POS_WAIT:
                if (status.mul_done) state_next = sodf_pkg::ST_T1_MUL;
            sodf_pkg::ST_T1_MUL:
                state_next = sodf_pkg::ST_T1_WAIT;
            sodf_pkg::ST_T1_WAIT:
                if (status.mul_done) state_next = sodf_pkg::ST_T3_MUL;
            sodf_pkg::ST_T3_MUL:
                state_next = sodf_pkg::ST_T3_WAIT;
            sodf_pkg::ST_T3_WAIT:
                if (status.mul_done)
                begin
                    state_next = status.step_zero ? sodf_pkg::ST_SUM : sodf_pkg::ST_T3_DIV;
                end
            sodf_pkg::ST_T3_DIV:
                state_next = sodf_pkg::ST_T3_DWAIT;
            sodf_pkg::ST_T3_DWAIT:
                if (status.div_done) state_next = sodf_pkg::ST_SUM;
            sodf_pkg::ST_SUM:
                if (status.inertia_zero || status.step_zero)
                begin
                    state_next = sodf_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sodf_pkg::ST_INC_MUL;
                end
            sodf_pkg::ST_INC_MUL:
                state_next = sodf_pkg::ST_INC_WAIT;
            sodf_pkg::ST_INC_WAIT:
                if (status.mul_done) state_next = sodf_pkg::ST_INC_DIV;
            sodf_pkg::ST_INC_DIV:
                state_next = sodf_pkg::ST_INC_DWAIT;
            sodf_pkg::ST_INC_DWAIT:
                if (status.div_done) state_next = sodf_pkg::ST_VEL;
            sodf_pkg::ST_VEL:
                state_next = sodf_pkg::ST_DONE;
            sodf_pkg::ST_DONE:
                if (status.out_free) state_next = sodf_pkg::ST_IDLE;
            default:
                state_next = sodf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            sodf_pkg::ST_IDLE:
                cmd.take = 1'b1;
            sodf_pkg::ST_POS_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sodf_pkg::MUL_POS;
            end
            sodf_pkg::ST_POS_WAIT:
                cmd.cap_pos = status.mul_done;
            sodf_pkg::ST_T1_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sodf_pkg::MUL_T1;
            end
            sodf_pkg::ST_T1_WAIT:
                cmd.cap_t1 = status.mul_done;
            sodf_pkg::ST_T3_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sodf_pkg::MUL_T3;
            end
            sodf_pkg::ST_T3_WAIT:
                cmd.cap_t3_zero = status.mul_done && status.step_zero;
            sodf_pkg::ST_T3_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sodf_pkg::DIV_T3;
            end
            sodf_pkg::ST_T3_DWAIT:
                cmd.cap_t3 = status.div_done;
            sodf_pkg::ST_SUM:
                cmd.cap_amount = 1'b1;
            sodf_pkg::ST_INC_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sodf_pkg::MUL_INC;
            end
            sodf_pkg::ST_INC_WAIT:
                cmd.mul_sel = sodf_pkg::MUL_INC;
            sodf_pkg::ST_INC_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sodf_pkg::DIV_INC;
            end
            sodf_pkg::ST_INC_DWAIT:
                cmd.div_sel = sodf_pkg::DIV_INC;
            sodf_pkg::ST_VEL:
                cmd.cap_vel = 1'b1;
            sodf_pkg::ST_DONE:
                cmd.commit = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== hdl/second_order_dynamics_follower.sv =====
// Second-order follower: each sample transfer steps a fixed-point mass-spring-damper
// (semi-implicit Euler) toward the target and returns one result transfer with the new
// position, a clip flag and a zero-inertia flag. One sample is worked at a time; its
// time is set by the two 112-step radix-2 divisions (rate term by the time step, velocity
// step by the inertia coefficient) on the shared one-bit-per-cycle divider, plus four
// 6-step multiplies on the shared 84x8 multiplier. A zero time step skips both divisions
// and the last multiply, zero inertia the last multiply and division. A new sample is
// taken while the previous result still waits in the output register. time_step may be
// written only while no sample is in flight.
module second_order_dynamics_follower (
    input  logic          clk,
    input  logic          rst_n,
    sodf_cfg_if.sink      cfg,
    sodf_sample_if.sink   sample,
    sodf_result_if.source result
);

    sodf_pkg::cmd_t    cmd;
    sodf_pkg::status_t status;

    sodf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sodf_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// ===== hdl/sodf_checker.sv =====
module sodf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              res_valid,
    input logic              res_ready,
    input sodf_pkg::signal_t position,
    input logic              saturated,
    input logic              coef_error
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_xfer;
    logic       res_xfer;

    assign in_xfer      = in_valid && in_ready;
    assign res_xfer     = res_valid && res_ready;
    assign pending_next = pending_reg + {1'b0, in_xfer} - {1'b0, res_xfer};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        $past(res_valid && !res_ready) |->
            $stable(position) && $stable(saturated) && $stable(coef_error))
        else $error("result payload changed while stalled");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("sample taken back to back");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result without a sample in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> pending_reg == 2'd0 || pending_reg == 2'd1)
        else $error("more than two samples in flight");

endmodule

bind second_order_dynamics_follower sodf_checker u_sodf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .position   (result.position),
    .saturated  (result.saturated),
    .coef_error (result.coef_error)
);
